[rtl/cbth_pkg.sv]
// Package for the chained block token hash: widths, hash constants, chain mode codes
// and the command and status types between controller and datapath.
// No dependencies.
package cbth_pkg;

    localparam int TOKEN_W = 32;
    localparam int MODE_W  = 2;
    localparam int HASH_W  = 64;
    localparam int HALF_W  = 32;
    localparam int CFG_W   = 11;

    localparam int MAX_TOKENS_DEFAULT = 1024;
    localparam logic [CFG_W-1:0] CFG_RESET = 11'd256;

    localparam logic [HASH_W-1:0] GOLDEN    = 64'h9e3779b97f4a7c15;
    localparam logic [HASH_W-1:0] MIX_A     = 64'hbf58476d1ce4e5b9;
    localparam logic [HASH_W-1:0] MIX_B     = 64'h94d049bb133111eb;
    localparam logic [HASH_W-1:0] SEED      = 64'h243f6a8885a308d3;
    localparam logic [HASH_W-1:0] LEN_BASE  = 64'h1c6e4a8dc4b3f8a1;
    localparam logic [HASH_W-1:0] NO_PREFIX = 64'hffffffffffffffff;

    localparam int SHIFT_A = 30;
    localparam int SHIFT_B = 27;
    localparam int SHIFT_F = 31;

    // Chain mode codes, read on a block's first token
    localparam logic [MODE_W-1:0] MODE_CONTINUE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SEED     = 2'd1;
    localparam logic [MODE_W-1:0] MODE_PREFIX   = 2'd2;

    // Operand pair for the shared 32x32 multiplier
    typedef enum logic [2:0] {
        MUL_LEN_LO,
        MUL_LEN_HI,
        MUL_LO_LO,
        MUL_LO_HI,
        MUL_HI_LO
    } mul_sel_t;

    // Accumulator update
    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_LOAD_BASE,
        ACC_ADD_HI
    } acc_op_t;

    // Working value update
    typedef enum logic [1:0] {
        V_HOLD,
        V_MIX_FIRST,
        V_MIX_NEXT,
        V_SHIFT
    } v_op_t;

    typedef struct packed {
        logic     load;
        mul_sel_t mul_sel;
        logic     phase_b;
        acc_op_t  acc_op;
        v_op_t    v_op;
        logic     finish;
    } dp_cmd_t;

    typedef struct packed {
        logic first;
        logic last;
    } dp_status_t;

endpackage

[rtl/chained_block_token_hash.sv]
// Channel   Dir  Handshake           Contents
// s_        in   s_tvalid/s_tready   token ids, chain mode, prefix hash
// m_        out  m_tvalid/m_tready   64-bit hash of each completed block
// cfg_      in   cfg_valid/cfg_ready tokens_per_block (always ready)
//
// Each token is handled by one 32x32 multiplier that builds each 64-bit multiply
// from three partial products, two multiplies per token plus the length term at
// block start; the next token is taken only once this one is finished.
// Reset is synchronous, active low, and clears the controller, the token count,
// the chain hash (to no prefix) and the block length (256).
// A finished hash waits in the output register; the next token is taken meanwhile,
// and only a further block end stalls until that result is taken.
//
// Top level of the chained block token hash. Depends on cbth_pkg, cbth_ctrl,
// cbth_datapath and cbth_mul32.
module chained_block_token_hash import cbth_pkg::*; #(
    parameter int MAX_TOKENS_PER_BLOCK = MAX_TOKENS_DEFAULT
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [TOKEN_W+HASH_W-1:0]  s_tdata,   // token [31:0], prefix_hash [95:32]
    input  logic [MODE_W-1:0]          s_tuser,   // chain_mode [1:0]
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [HASH_W-1:0]          m_tdata,   // block_hash [63:0]
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CFG_W-1:0]           cfg_data
);

    dp_cmd_t    cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    cbth_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    cbth_datapath #(
        .MAX_TOKENS_PER_BLOCK (MAX_TOKENS_PER_BLOCK)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_data    (cfg_data),
        .cmd         (cmd),
        .status      (status),
        .token       (s_tdata[TOKEN_W-1:0]),
        .chain_mode  (s_tuser),
        .prefix_hash (s_tdata[TOKEN_W+HASH_W-1:TOKEN_W]),
        .block_hash  (m_tdata)
    );

endmodule

[rtl/cbth_mul32.sv]
// Registered 32x32 unsigned multiplier with a full 64-bit product.
// Depends on cbth_pkg for widths.
module cbth_mul32 import cbth_pkg::*; (
    input  logic                aclk,
    input  logic [HALF_W-1:0]   op_a,
    input  logic [HALF_W-1:0]   op_b,
    output logic [2*HALF_W-1:0] prod
);

    logic [2*HALF_W-1:0] prod_reg;
    logic [2*HALF_W-1:0] prod_next;

    // Full product, no truncation
    assign prod_next = {{HALF_W{1'b0}}, op_a} * {{HALF_W{1'b0}}, op_b};

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

[rtl/cbth_datapath.sv]
// Datapath of the chained block token hash: config register, chain state, working
// registers and the 64-bit modular multiplies built from one shared 32x32 multiplier.
// Depends on cbth_pkg and cbth_mul32.
module cbth_datapath import cbth_pkg::*; #(
    parameter int MAX_TOKENS_PER_BLOCK = MAX_TOKENS_DEFAULT
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_valid,
    input  logic [CFG_W-1:0]    cfg_data,
    input  dp_cmd_t             cmd,
    output dp_status_t          status,
    input  logic [TOKEN_W-1:0]  token,
    input  logic [MODE_W-1:0]   chain_mode,
    input  logic [HASH_W-1:0]   prefix_hash,
    output logic [HASH_W-1:0]   block_hash
);

    logic [CFG_W-1:0]    cfg_reg;
    logic [CFG_W-1:0]    count_reg;
    logic [CFG_W-1:0]    count_next;
    logic [HASH_W-1:0]   last_hash_reg;
    logic [HASH_W-1:0]   running_reg;
    logic [TOKEN_W-1:0]  token_reg;
    logic [HASH_W-1:0]   start_reg;
    logic [HASH_W-1:0]   start_next;
    logic [HASH_W-1:0]   v_reg;
    logic [HASH_W-1:0]   v_next;
    logic [HASH_W-1:0]   acc_reg;
    logic [HASH_W-1:0]   acc_next;
    logic [HASH_W-1:0]   out_reg;

    logic [CFG_W-1:0]    len;
    logic [CFG_W:0]      count_inc;
    logic [HASH_W-1:0]   start_sel;
    logic [HASH_W-1:0]   x_opd;
    logic [HASH_W-1:0]   mix_const;
    logic [HASH_W-1:0]   fin_hash;
    logic [HALF_W-1:0]   op_a;
    logic [HALF_W-1:0]   op_b;
    logic [2*HALF_W-1:0] prod;

    // Effective block length: zero acts as one, clamp to the maximum
    always_comb begin
        if (cfg_reg == '0) begin
            len = CFG_W'(1);
        end else if (32'(cfg_reg) > 32'(MAX_TOKENS_PER_BLOCK)) begin
            len = CFG_W'(MAX_TOKENS_PER_BLOCK);
        end else begin
            len = cfg_reg;
        end
    end

    assign count_inc    = {1'b0, count_reg} + (CFG_W+1)'(1);
    assign status.first = (count_reg == '0);
    assign status.last  = (count_inc >= {1'b0, len});
    assign count_next   = status.last ? '0 : count_inc[CFG_W-1:0];

    // Pick the block start value from the chain mode
    always_comb begin
        case (chain_mode)
            MODE_CONTINUE: start_sel = last_hash_reg;
            MODE_PREFIX:   start_sel = prefix_hash;
            default:       start_sel = NO_PREFIX;
        endcase
        start_next = (start_sel == NO_PREFIX) ? SEED : start_sel;
    end

    // Multiplier operands: first mix stage shifts here, second stage is pre-shifted
    assign x_opd     = cmd.phase_b ? v_reg : (v_reg ^ (v_reg >> SHIFT_A));
    assign mix_const = cmd.phase_b ? MIX_B : MIX_A;

    always_comb begin
        case (cmd.mul_sel)
            MUL_LEN_LO: begin
                op_a = HALF_W'(len);
                op_b = GOLDEN[HALF_W-1:0];
            end
            MUL_LEN_HI: begin
                op_a = HALF_W'(len);
                op_b = GOLDEN[HASH_W-1:HALF_W];
            end
            MUL_LO_HI: begin
                op_a = x_opd[HALF_W-1:0];
                op_b = mix_const[HASH_W-1:HALF_W];
            end
            MUL_HI_LO: begin
                op_a = x_opd[HASH_W-1:HALF_W];
                op_b = mix_const[HALF_W-1:0];
            end
            default: begin
                op_a = x_opd[HALF_W-1:0];
                op_b = mix_const[HALF_W-1:0];
            end
        endcase
    end

    cbth_mul32 u_mul (
        .aclk (aclk),
        .op_a (op_a),
        .op_b (op_b),
        .prod (prod)
    );

    // Accumulate partial products modulo 2^64
    always_comb begin
        case (cmd.acc_op)
            ACC_LOAD:      acc_next = prod;
            ACC_LOAD_BASE: acc_next = prod + LEN_BASE;
            ACC_ADD_HI:    acc_next = acc_reg + {prod[HALF_W-1:0], {HALF_W{1'b0}}};
            default:       acc_next = acc_reg;
        endcase
    end

    // Working value: fold in the token, or shift the first product
    always_comb begin
        case (cmd.v_op)
            V_MIX_FIRST: v_next = (start_reg ^ acc_reg ^ {{HALF_W{1'b0}}, token_reg}) + GOLDEN;
            V_MIX_NEXT:  v_next = (running_reg ^ {{HALF_W{1'b0}}, token_reg}) + GOLDEN;
            V_SHIFT:     v_next = acc_reg ^ (acc_reg >> SHIFT_B);
            default:     v_next = v_reg;
        endcase
    end

    assign fin_hash = acc_reg ^ (acc_reg >> SHIFT_F);

    // Config and chain state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg       <= CFG_RESET;
            count_reg     <= '0;
            last_hash_reg <= NO_PREFIX;
            running_reg   <= '0;
        end else begin
            if (cfg_valid) begin
                cfg_reg <= cfg_data;
            end
            if (cmd.finish) begin
                count_reg   <= count_next;
                running_reg <= fin_hash;
                if (status.last) begin
                    last_hash_reg <= fin_hash;
                end
            end
        end
    end

    // Working registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            token_reg <= token;
            start_reg <= start_next;
        end
        acc_reg <= acc_next;
        v_reg   <= v_next;
        if (cmd.finish && status.last) begin
            out_reg <= fin_hash;
        end
    end

    assign block_hash = out_reg;

endmodule

[rtl/cbth_ctrl.sv]
// Controller of the chained block token hash: sequences the length term and the two
// 64-bit mix multiplies, and owns the input ready and the result valid.
// Depends on cbth_pkg.
module cbth_ctrl import cbth_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    output logic       m_tvalid,
    input  logic       m_tready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LEN0,
        ST_LEN1,
        ST_LEN2,
        ST_MIXIN,
        ST_A0,
        ST_A1,
        ST_A2,
        ST_A3,
        ST_SHIFT,
        ST_B0,
        ST_B1,
        ST_B2,
        ST_B3,
        ST_FIN
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   fin_go;

    // A finished block needs a free result slot
    assign fin_go = (state_reg == ST_FIN) &&
                    (!status.last || !out_valid_reg || m_tready);

    // Command decode and next state
    always_comb begin
        cmd        = '{load: 1'b0, mul_sel: MUL_LO_LO, phase_b: 1'b0,
                       acc_op: ACC_HOLD, v_op: V_HOLD, finish: 1'b0};
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                cmd.load = s_tvalid;
                if (s_tvalid) begin
                    state_next = status.first ? ST_LEN0 : ST_MIXIN;
                end
            end
            ST_LEN0: begin
                cmd.mul_sel = MUL_LEN_LO;
                state_next  = ST_LEN1;
            end
            ST_LEN1: begin
                cmd.mul_sel = MUL_LEN_HI;
                cmd.acc_op  = ACC_LOAD_BASE;
                state_next  = ST_LEN2;
            end
            ST_LEN2: begin
                cmd.acc_op = ACC_ADD_HI;
                state_next = ST_MIXIN;
            end
            ST_MIXIN: begin
                cmd.v_op   = status.first ? V_MIX_FIRST : V_MIX_NEXT;
                state_next = ST_A0;
            end
            ST_A0: begin
                cmd.mul_sel = MUL_LO_LO;
                state_next  = ST_A1;
            end
            ST_A1: begin
                cmd.mul_sel = MUL_LO_HI;
                cmd.acc_op  = ACC_LOAD;
                state_next  = ST_A2;
            end
            ST_A2: begin
                cmd.mul_sel = MUL_HI_LO;
                cmd.acc_op  = ACC_ADD_HI;
                state_next  = ST_A3;
            end
            ST_A3: begin
                cmd.acc_op = ACC_ADD_HI;
                state_next = ST_SHIFT;
            end
            ST_SHIFT: begin
                cmd.v_op   = V_SHIFT;
                state_next = ST_B0;
            end
            ST_B0: begin
                cmd.mul_sel = MUL_LO_LO;
                cmd.phase_b = 1'b1;
                state_next  = ST_B1;
            end
            ST_B1: begin
                cmd.mul_sel = MUL_LO_HI;
                cmd.phase_b = 1'b1;
                cmd.acc_op  = ACC_LOAD;
                state_next  = ST_B2;
            end
            ST_B2: begin
                cmd.mul_sel = MUL_HI_LO;
                cmd.phase_b = 1'b1;
                cmd.acc_op  = ACC_ADD_HI;
                state_next  = ST_B3;
            end
            ST_B3: begin
                cmd.phase_b = 1'b1;
                cmd.acc_op  = ACC_ADD_HI;
                state_next  = ST_FIN;
            end
            ST_FIN: begin
                cmd.finish = fin_go;
                if (fin_go) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Result valid: drop on take, raise on a finished block
    assign out_valid_next = (out_valid_reg && !m_tready) || (fin_go && status.last);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;

endmodule

[rtl/cbth_checker.sv]
// Port-level checker for the chained block token hash, bound to the top level.
// Depends on cbth_pkg for widths.
module cbth_checker import cbth_pkg::*; (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_tvalid,
    input logic              s_tready,
    input logic              m_tvalid,
    input logic              m_tready,
    input logic [HASH_W-1:0] m_tdata
);

    // Hold a stalled result
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result data changed while stalled");

    // One token in flight: ready drops after each request
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second request taken while busy");

    // A result cannot appear in the cycle right after a request
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !$rose(m_tvalid))
        else $error("result raised too early");

    // Reset empties the result slot
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind chained_block_token_hash cbth_checker u_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
